[hw/rtl/gamepad_report_decoder_assert.svh]
// Assertion macros for the gamepad report decoder.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef GAMEPAD_REPORT_DECODER_ASSERT_SVH
`define GAMEPAD_REPORT_DECODER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define GRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another on the next clock edge.
`define GRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/grd_pkg.sv]
// Shared types and constants of the gamepad report decoder.
// No dependencies.
package grd_pkg;

  localparam int unsigned STORE_BYTES = 16;
  localparam int unsigned IDX_W       = $clog2(STORE_BYTES);
  localparam int unsigned CNT_W       = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;
  localparam logic KIND_8BIT  = 1'b0;
  localparam logic KIND_16BIT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic               status;
    logic               pad_kind;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [9:0]         left_pull;
    logic [9:0]         right_pull;
    logic [7:0]         hat;
    logic [10:0]        button_mask;
  } out_t;

  typedef struct packed {
    logic [STORE_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]            len;
  } report_t;

endpackage

[hw/rtl/grd_front.sv]
// Front end: collects report bytes and hands each finished report on.
// Depends on grd_pkg.
module grd_front import grd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  in_t     in_i,
  input  logic    q_full_i,
  output logic    push_o,
  output report_t push_data_o
);

  logic [CNT_W-1:0]            count_q, count_d;
  logic [STORE_BYTES-1:0][7:0] buf_q;
  logic [CNT_W-1:0]            len_new;
  logic                        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len_new    = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);
  assign push_o     = accept && in_i.last_byte;

  always_comb begin
    count_d = count_q;
    if (accept) begin
      count_d = in_i.last_byte ? '0 : len_new;
    end
  end

  // Zero every byte at or past the report length.
  always_comb begin
    push_data_o.len = len_new;
    for (int i = 0; i < STORE_BYTES; i++) begin
      if (CNT_W'(i) >= len_new) begin
        push_data_o.bytes[i] = '0;
      end else if (CNT_W'(i) == count_q) begin
        push_data_o.bytes[i] = in_i.data_byte;
      end else begin
        push_data_o.bytes[i] = buf_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (count_q < CNT_W'(STORE_BYTES))) begin
      buf_q[count_q[IDX_W-1:0]] <= in_i.data_byte;
    end
  end

endmodule

[hw/rtl/grd_queue.sv]
// Short report queue between front and back end.
// Depends on grd_pkg.
module grd_queue import grd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  report_t push_data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    pop_i,
  output report_t data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  report_t           entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/grd_back.sv]
// Back end: detects the pad layout, decodes one report and holds the result.
// Depends on grd_pkg and gamepad_report_decoder_assert.svh.
`include "gamepad_report_decoder_assert.svh"

module grd_back import grd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  report_t q_data_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output out_t    out_o
);

  localparam logic [7:0] REPORT_ID = 8'h01;
  localparam logic [7:0] NEAR_LO   = 8'd64;
  localparam logic [7:0] NEAR_HI   = 8'd192;
  localparam logic [7:0] HIGH_LO   = 8'h70;
  localparam logic [7:0] HIGH_HI   = 8'h90;
  localparam logic [7:0] TRIG_IDLE = 8'd30;
  localparam int unsigned SEL_N    = 10;

  logic       kind_known_q, kind_value_q;
  logic       out_valid_q;
  out_t       out_q, res;
  logic [7:0] len, l_len;
  logic       skip;
  logic [SEL_N-1:0][7:0]       s;
  logic [STORE_BYTES-1:0][7:0] b;
  logic       near, high, det_kind, kind;

  function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // (v - 128) * 32767 / 127 is about 258 * (v - 128): a unit step is added at 1 and 255, and 0 gives -32768.
  function automatic logic [15:0] conv8(input logic [7:0] v);
    logic signed [8:0]  x;
    logic signed [17:0] p;
    x = $signed({1'b0, v}) - 9'sd128;
    p = 18'(x) * 18'sd258;
    if (v == 8'd0) begin
      p = -18'sd32768;
    end else if (v == 8'd1) begin
      p = p - 18'sd1;
    end else if (v == 8'd255) begin
      p = p + 18'sd1;
    end
    return p[15:0];
  endfunction

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign b     = q_data_i.bytes;
  assign len   = q_data_i.len;
  assign skip  = (b[0] == REPORT_ID) && (len >= 8'd10);
  assign l_len = len - {7'd0, skip};

  always_comb begin
    for (int k = 0; k < SEL_N; k++) begin
      s[k] = skip ? b[k + 1] : b[k];
    end
  end

  assign near = in_range(s[0], NEAR_LO, NEAR_HI) && in_range(s[1], NEAR_LO, NEAR_HI) &&
                in_range(s[2], NEAR_LO, NEAR_HI) && in_range(s[3], NEAR_LO, NEAR_HI);
  assign high = in_range(s[1], HIGH_LO, HIGH_HI) && in_range(s[3], HIGH_LO, HIGH_HI);

  always_comb begin
    if (near && (s[4] < TRIG_IDLE) && (s[5] < TRIG_IDLE)) begin
      det_kind = KIND_8BIT;
    end else if (high && (l_len >= 8'd14) && in_range(s[5], HIGH_LO, HIGH_HI) &&
                 in_range(s[7], HIGH_LO, HIGH_HI)) begin
      det_kind = KIND_16BIT;
    end else if (near || (l_len <= 8'd12)) begin
      det_kind = KIND_8BIT;
    end else begin
      det_kind = KIND_16BIT;
    end
  end

  assign kind = kind_known_q ? kind_value_q : det_kind;

  always_comb begin
    res        = '0;
    res.status = STATUS_ERR;
    if (len >= 8'd8) begin
      if (kind == KIND_8BIT) begin
        if (l_len >= 8'd10) begin
          res.status      = STATUS_OK;
          res.pad_kind    = KIND_8BIT;
          res.left_x      = conv8(s[0]);
          res.left_y      = conv8(s[1]);
          res.right_x     = conv8(s[2]);
          res.right_y     = conv8(s[3]);
          res.left_pull   = {s[4], 2'b00};
          res.right_pull  = {s[5], 2'b00};
          res.hat         = {4'd0, s[7][3:0]};
          res.button_mask = {s[8][7], s[8][6], (l_len >= 8'd11) && s[9][0],
                             s[8][5], s[8][4], s[8][1], s[8][0],
                             s[7][7], s[7][4], s[7][6], s[7][5]};
        end
      end else if (len >= 8'd14) begin
        res.status      = STATUS_OK;
        res.pad_kind    = KIND_16BIT;
        res.left_x      = {~b[1][7], b[1][6:0], b[0]};
        res.left_y      = {~b[3][7], b[3][6:0], b[2]};
        res.right_x     = {~b[5][7], b[5][6:0], b[4]};
        res.right_y     = {~b[7][7], b[7][6:0], b[6]};
        res.left_pull   = {b[9][1:0], b[8]};
        res.right_pull  = {b[11][1:0], b[10]};
        res.hat         = b[12];
        res.button_mask = {b[14][6], b[14][5], b[14][4], b[14][3], b[14][2],
                           b[13][7], b[13][6], b[13][4], b[13][3], b[13][1], b[13][0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_known_q <= 1'b0;
      kind_value_q <= KIND_8BIT;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        if (!kind_known_q && (len >= 8'd8)) begin
          kind_known_q <= 1'b1;
          kind_value_q <= det_kind;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  `GRD_ASSERT_NEXT(a_kind_sticky, kind_known_q, kind_known_q && $stable(kind_value_q), "pad layout changed after detection")
  `GRD_ASSERT(a_kind_reset, !kind_known_q |-> (kind_value_q == KIND_8BIT), "layout set before detection")
  `GRD_ASSERT(a_pop_has_item, pop_o |-> q_valid_i, "pop from empty queue")
  `GRD_ASSERT(a_err_zero, (out_valid_q && out_q.status) |-> (out_q.pad_kind == 1'b0 && out_q.left_x == '0 && out_q.right_y == '0 && out_q.hat == '0 && out_q.button_mask == '0), "error result carries data")

endmodule

[hw/rtl/gamepad_report_decoder.sv]
// Gamepad report decoder: one report byte accepted per cycle, when the report queue has room.
// A finished report is registered in the queue, then decoded into the output register when
// that is free; up to two finished reports wait in the queue while the output stalls.
// Throughput: one byte per cycle (queue not full), one decoded report per cycle (output taken).
// Reset clears the byte count, queue, detected layout and output valid; the byte store is
// not cleared, and bytes past the report length read as zero.
module gamepad_report_decoder import grd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  logic    push, q_full, q_valid, pop;
  report_t push_data, q_data;

  grd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  grd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .data_o      (q_data)
  );

  grd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
